// File: rtl/fcfl_pkg.sv
`timescale 1ns / 1ps

package fcfl_pkg;

    localparam int NUM_CHUNKS = 1024;
    localparam int IDX_W      = 10;
    localparam int PTR_W      = 11;
    localparam int CFG_W      = 17;
    localparam int OFS_W      = 27;

    localparam logic [PTR_W-1:0] NULL_PTR        = PTR_W'(NUM_CHUNKS);
    localparam logic [PTR_W-1:0] LAST_PTR        = PTR_W'(NUM_CHUNKS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX        = IDX_W'(NUM_CHUNKS - 1);
    localparam logic [CFG_W-1:0] MIN_CHUNK_BYTES = CFG_W'(8);
    localparam logic [CFG_W-1:0] CHUNK_BYTES_RST = CFG_W'(9216);

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_POP
    } state_t;

    typedef struct packed {
        logic init_step;
        logic release_word;
        logic push;
        logic pop_rd;
        logic pop_fin;
        logic alloc_fail;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic head_null;
        logic rel_ok;
    } sts_t;

endpackage

// File: rtl/fcfl_ram.sv
`timescale 1ns / 1ps

module fcfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fcfl_ctrl.sv
`timescale 1ns / 1ps

module fcfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    output logic              out_valid,
    input  logic              out_stall,
    input  fcfl_pkg::sts_t    sts,
    output fcfl_pkg::cmd_t    cmd
);

    fcfl_pkg::state_t state_reg;
    fcfl_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcfl_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == fcfl_pkg::ST_IDLE) && out_free);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            fcfl_pkg::ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                begin
                    state_next = fcfl_pkg::ST_IDLE;
                end
            end
            fcfl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (fcfl_pkg::op_t'(operation) == fcfl_pkg::OP_RELEASE)
                    begin
                        cmd.release_word = 1'b1;
                        cmd.push         = sts.rel_ok;
                    end
                    else if (sts.head_null)
                    begin
                        cmd.alloc_fail = 1'b1;
                    end
                    else
                    begin
                        cmd.pop_rd = 1'b1;
                        state_next = fcfl_pkg::ST_POP;
                    end
                end
            end
            fcfl_pkg::ST_POP:
            begin
                cmd.pop_fin = 1'b1;
                state_next  = fcfl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fcfl_pkg::ST_INIT;
            end
        endcase

        if (cmd.release_word || cmd.alloc_fail || cmd.pop_fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// File: rtl/fcfl_dp.sv
`timescale 1ns / 1ps

module fcfl_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcfl_pkg::cmd_t                cmd,
    output fcfl_pkg::sts_t                sts,
    input  logic [fcfl_pkg::PTR_W-1:0]    release_index,
    input  logic                          cfg_wr_en,
    input  logic [fcfl_pkg::CFG_W-1:0]    cfg_wr_data,
    output logic                          granted,
    output logic [fcfl_pkg::IDX_W-1:0]    granted_index,
    output logic [fcfl_pkg::OFS_W-1:0]    granted_offset,
    output logic                          pool_empty
);

    logic [fcfl_pkg::PTR_W-1:0] head_reg;
    logic [fcfl_pkg::PTR_W-1:0] head_next;
    logic [fcfl_pkg::IDX_W-1:0] init_cnt_reg;
    logic [fcfl_pkg::CFG_W-1:0] chunk_bytes_reg;
    logic [fcfl_pkg::CFG_W-1:0] eff_bytes;
    logic                       granted_reg;
    logic [fcfl_pkg::IDX_W-1:0] granted_index_reg;
    logic [fcfl_pkg::OFS_W-1:0] granted_offset_reg;
    logic                       pool_empty_reg;

    logic                       ram_we;
    logic [fcfl_pkg::IDX_W-1:0] ram_waddr;
    logic [fcfl_pkg::PTR_W-1:0] ram_wdata;
    logic [fcfl_pkg::PTR_W-1:0] ram_rdata;
    logic [fcfl_pkg::PTR_W-1:0] init_link;
    logic [fcfl_pkg::OFS_W-1:0] offset;

    // link store, one next-free pointer per chunk
    fcfl_ram #(
        .WIDTH (fcfl_pkg::PTR_W),
        .DEPTH (fcfl_pkg::NUM_CHUNKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.pop_rd),
        .raddr (head_reg[fcfl_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign init_link = (init_cnt_reg == '0) ? fcfl_pkg::NULL_PTR
                     : fcfl_pkg::PTR_W'(init_cnt_reg - fcfl_pkg::IDX_W'(1));

    assign ram_we    = cmd.init_step || cmd.push;
    assign ram_waddr = cmd.init_step ? init_cnt_reg : release_index[fcfl_pkg::IDX_W-1:0];
    assign ram_wdata = cmd.init_step ? init_link : head_reg;

    assign eff_bytes = (chunk_bytes_reg < fcfl_pkg::MIN_CHUNK_BYTES)
                     ? fcfl_pkg::MIN_CHUNK_BYTES : chunk_bytes_reg;
    assign offset    = fcfl_pkg::OFS_W'(head_reg[fcfl_pkg::IDX_W-1:0])
                     * fcfl_pkg::OFS_W'(eff_bytes);

    assign sts.init_last = (init_cnt_reg == fcfl_pkg::LAST_IDX);
    assign sts.head_null = (head_reg >= fcfl_pkg::NULL_PTR);
    assign sts.rel_ok    = (release_index < fcfl_pkg::NULL_PTR);

    always_comb
    begin
        head_next = head_reg;
        if (cmd.push)
        begin
            head_next = release_index;
        end
        else if (cmd.pop_fin)
        begin
            head_next = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= fcfl_pkg::LAST_PTR;
            init_cnt_reg    <= '0;
            chunk_bytes_reg <= fcfl_pkg::CHUNK_BYTES_RST;
        end
        else
        begin
            head_reg <= head_next;
            if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + fcfl_pkg::IDX_W'(1);
            end
            if (cfg_wr_en)
            begin
                chunk_bytes_reg <= cfg_wr_data;
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.pop_fin)
        begin
            granted_reg        <= 1'b1;
            granted_index_reg  <= head_reg[fcfl_pkg::IDX_W-1:0];
            granted_offset_reg <= offset;
            pool_empty_reg     <= (ram_rdata >= fcfl_pkg::NULL_PTR);
        end
        else if (cmd.release_word || cmd.alloc_fail)
        begin
            granted_reg        <= 1'b0;
            granted_index_reg  <= '0;
            granted_offset_reg <= '0;
            pool_empty_reg     <= cmd.push ? 1'b0 : sts.head_null;
        end
    end

    assign granted        = granted_reg;
    assign granted_index  = granted_index_reg;
    assign granted_offset = granted_offset_reg;
    assign pool_empty     = pool_empty_reg;

endmodule

// File: rtl/fixed_chunk_free_list_pool_core.sv
`timescale 1ns / 1ps
// channel   direction   handshake              payload
// in        input       in_valid / in_stall    operation, release_index
// out       output      out_valid / out_stall  granted, granted_index,
//                                              granted_offset, pool_empty
// cfg       input       cfg_wr_en              cfg_wr_data (chunk_bytes)
//
// allocate passes through ST_IDLE and ST_POP: the link of the head is read from the link ram
// release and allocate from an empty pool give their result word in the cycle after they are taken
// after reset all 1024 link ram entries are initialized while in_stall is high
// a result word held by out_stall keeps in_stall high until it is taken

module fixed_chunk_free_list_pool_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [fcfl_pkg::PTR_W-1:0]    release_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          granted,
    output logic [fcfl_pkg::IDX_W-1:0]    granted_index,
    output logic [fcfl_pkg::OFS_W-1:0]    granted_offset,
    output logic                          pool_empty,
    input  logic                          cfg_wr_en,
    input  logic [fcfl_pkg::CFG_W-1:0]    cfg_wr_data
);

    fcfl_pkg::cmd_t cmd;
    fcfl_pkg::sts_t sts;

    fcfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    fcfl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .release_index  (release_index),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .granted        (granted),
        .granted_index  (granted_index),
        .granted_offset (granted_offset),
        .pool_empty     (pool_empty)
    );

endmodule

// File: rtl/fcfl_checker.sv
`timescale 1ns / 1ps

module fcfl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          operation,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          granted,
    input logic [fcfl_pkg::IDX_W-1:0]    granted_index,
    input logic [fcfl_pkg::OFS_W-1:0]    granted_offset,
    input logic                          pool_empty
);

    // release answers in the next cycle, never with a grant
    a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation == fcfl_pkg::OP_RELEASE)
        |=> (out_valid && !granted))
        else $error("release word missing or granted");

    // no grant means zero index and offset
    a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !granted) |-> (granted_index == '0 && granted_offset == '0))
        else $error("non-grant carries index or offset");

    // a grant at chunk zero sits at offset zero
    a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && granted && granted_index == '0) |-> (granted_offset == '0))
        else $error("chunk zero with nonzero offset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall)
        |=> (out_valid && $stable(granted) && $stable(granted_index)
             && $stable(granted_offset) && $stable(pool_empty)))
        else $error("stalled output word changed");

endmodule

bind fixed_chunk_free_list_pool_core fcfl_checker u_fcfl_checker (.*);

// File: tb/fixed_chunk_free_list_pool_core_tb.sv
`timescale 1ns / 1ps

module fixed_chunk_free_list_pool_core_tb;

    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic                       granted;
        logic [fcfl_pkg::IDX_W-1:0] chunk;
        logic [fcfl_pkg::OFS_W-1:0] offset;
        logic                       empty;
    } grant_t;

    class pool_scoreboard;
        logic [fcfl_pkg::PTR_W-1:0] next_free [fcfl_pkg::NUM_CHUNKS];
        logic [fcfl_pkg::PTR_W-1:0] head;
        logic [fcfl_pkg::CFG_W-1:0] chunk_bytes;
        grant_t                     expected_grants[$];
        int                         mismatches;

        function void reset_pool();
            int i;
            for (i = 0; i < fcfl_pkg::NUM_CHUNKS; i++)
                next_free[i] = (i == 0) ? fcfl_pkg::NULL_PTR : fcfl_pkg::PTR_W'(i - 1);
            head = fcfl_pkg::LAST_PTR;
            chunk_bytes = fcfl_pkg::CHUNK_BYTES_RST;
            mismatches = 0;
            expected_grants.delete();
        endfunction

        function void set_chunk_bytes(logic [fcfl_pkg::CFG_W-1:0] value);
            chunk_bytes = value;
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        function void note_word(fcfl_pkg::op_t op, logic [fcfl_pkg::PTR_W-1:0] idx);
            grant_t                     g;
            logic [fcfl_pkg::CFG_W-1:0] size;
            logic [63:0]                product;
            g = '0;
            if (op == fcfl_pkg::OP_ALLOC)
            begin
                if (head < fcfl_pkg::NULL_PTR)
                begin
                    size = (chunk_bytes < fcfl_pkg::MIN_CHUNK_BYTES)
                         ? fcfl_pkg::MIN_CHUNK_BYTES : chunk_bytes;
                    product = 64'(head) * 64'(size);
                    g.granted = 1'b1;
                    g.chunk = head[fcfl_pkg::IDX_W-1:0];
                    g.offset = product[fcfl_pkg::OFS_W-1:0];
                    head = next_free[head];
                end
            end
            else if (idx < fcfl_pkg::NULL_PTR)
            begin
                next_free[idx] = head;
                head = idx;
            end
            g.empty = (head >= fcfl_pkg::NULL_PTR);
            expected_grants = {expected_grants, g};
        endfunction

        function void check_word(grant_t got);
            grant_t want;
            if (expected_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: granted=%0d index=%0d offset=%0d empty=%0d",
                             got.granted, got.chunk, got.offset, got.empty);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.granted, want.chunk, want.offset, want.empty,
                                 got.granted, got.chunk, got.offset, got.empty);
                end
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       operation;
    logic [fcfl_pkg::PTR_W-1:0] release_index;
    logic                       out_valid;
    logic                       out_stall;
    logic                       granted;
    logic [fcfl_pkg::IDX_W-1:0] granted_index;
    logic [fcfl_pkg::OFS_W-1:0] granted_offset;
    logic                       pool_empty;
    logic                       cfg_wr_en;
    logic [fcfl_pkg::CFG_W-1:0] cfg_wr_data;

    pool_scoreboard             sb;
    grant_t                     seen;
    logic [fcfl_pkg::PTR_W-1:0] held_chunks[$];
    logic [fcfl_pkg::PTR_W-1:0] spare;
    int                         send_idle_pct;
    int                         recv_idle_pct;
    int                         quiet_cycles;
    int                         hold_left;
    bit                         hold_req;

    fixed_chunk_free_list_pool_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .release_index  (release_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted        (granted),
        .granted_index  (granted_index),
        .granted_offset (granted_offset),
        .pool_empty     (pool_empty),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(fcfl_pkg::op_t'(operation), release_index);
            if (out_valid && !out_stall)
            begin
                seen.granted = granted;
                seen.chunk = granted_index;
                seen.offset = granted_offset;
                seen.empty = pool_empty;
                sb.check_word(seen);
                if (granted === 1'b1)
                    held_chunks = {held_chunks, fcfl_pkg::PTR_W'(granted_index)};
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_word(input fcfl_pkg::op_t op, input logic [fcfl_pkg::PTR_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        operation = op;
        release_index = idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_chunk_bytes(input logic [fcfl_pkg::CFG_W-1:0] value);
        wait_drain();
        repeat (5) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        sb.set_chunk_bytes(value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // releases mostly hand back chunks we hold; wild ones may free a chunk twice
    task automatic random_word(input int alloc_pct, input int wild_pct);
        int                         pick;
        int                         pos;
        logic [fcfl_pkg::PTR_W-1:0] idx;
        pick = $urandom_range(99);
        if (pick < alloc_pct)
            send_word(fcfl_pkg::OP_ALLOC, fcfl_pkg::PTR_W'($urandom_range(2047)));
        else
        begin
            pick = $urandom_range(99);
            if (pick < wild_pct)
                idx = fcfl_pkg::PTR_W'($urandom_range(fcfl_pkg::NUM_CHUNKS - 1));
            else if (pick < wild_pct + 8 || held_chunks.size() == 0)
                idx = fcfl_pkg::PTR_W'($urandom_range(2047, fcfl_pkg::NUM_CHUNKS));
            else
            begin
                pos = $urandom_range(held_chunks.size() - 1);
                idx = held_chunks[pos];
                held_chunks.delete(pos);
            end
            send_word(fcfl_pkg::OP_RELEASE, idx);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = fcfl_pkg::OP_ALLOC;
        release_index = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 14;
        recv_idle_pct = 73;
        sb = new;
        sb.reset_pool();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send_word(fcfl_pkg::OP_ALLOC, '0);
        send_word(fcfl_pkg::OP_ALLOC, '1);
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::NULL_PTR);
        send_word(fcfl_pkg::OP_RELEASE, '1);
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::PTR_W'(1025));
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::LAST_PTR);
        send_word(fcfl_pkg::OP_ALLOC, fcfl_pkg::PTR_W'(1023));
        send_word(fcfl_pkg::OP_ALLOC, fcfl_pkg::PTR_W'(1024));
        send_word(fcfl_pkg::OP_ALLOC, fcfl_pkg::PTR_W'(5));
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::PTR_W'(1022));
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::PTR_W'(1020));
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::PTR_W'(1021));
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::LAST_PTR);
        repeat (4) send_word(fcfl_pkg::OP_ALLOC, fcfl_pkg::PTR_W'($urandom_range(2047)));
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::PTR_W'(1021));
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::PTR_W'(1020));
        send_word(fcfl_pkg::OP_RELEASE, fcfl_pkg::NULL_PTR);
        wait_drain();
        held_chunks.delete();

        write_chunk_bytes(fcfl_pkg::MIN_CHUNK_BYTES);
        repeat (360) random_word(95, 0);
        write_chunk_bytes('1);
        repeat (360) random_word(95, 0);

        send_idle_pct = 73;
        recv_idle_pct = 14;
        write_chunk_bytes('0);
        repeat (150) random_word(95, 0);
        wait_drain();
        repeat (150) random_word(95, 0);
        write_chunk_bytes(fcfl_pkg::CFG_W'(65536));
        repeat (250) random_word(80, 0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_chunk_bytes(fcfl_pkg::CFG_W'(7));
        repeat (50) random_word(50, 0);
        // hold the result words back with one out_stall burst so the pool core stalls its input
        hold_req = 1'b1;
        repeat (200) random_word(50, 0);
        write_chunk_bytes(fcfl_pkg::CFG_W'($urandom_range(65536, 8)));
        repeat (230) random_word(35, 0);

        // double release last, since it leaves a loop in the free list
        wait_drain();
        send_word(fcfl_pkg::OP_ALLOC, '0);
        wait_drain();
        if (held_chunks.size() != 0)
            spare = held_chunks.pop_back();
        else
            spare = fcfl_pkg::LAST_PTR;
        send_word(fcfl_pkg::OP_RELEASE, spare);
        send_word(fcfl_pkg::OP_RELEASE, spare);
        repeat (3) send_word(fcfl_pkg::OP_ALLOC, '1);
        repeat (40) random_word(50, 30);

        wait_drain();
        repeat (20) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
